[hdl/hkfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hkfc_pkg;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  localparam int KEY_BYTE_W  = 8;
  localparam int HIT_W       = 20;
  localparam int BUCKET_W    = 10;
  localparam int UNIQ_W      = 13;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_FULL = 2'd1;
  localparam status_t STATUS_LONG = 2'd2;

endpackage
`default_nettype wire

[hdl/hkfc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module hkfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/hashed_key_frequency_counter.sv]
`timescale 1ns / 1ps
`default_nettype none
// hashed key frequency counter
// in_*: one key byte per request in in_tdata, in_tlast on the final byte of the key.
// out_*: one result per key: tdata = hit_count, bucket, unique_total;
//   tuser = is_new, status (0 ok, 1 pool full, 2 key too long).
// non-final bytes are taken one per cycle while in_tready is high. a final byte
// reduces the fnv-1a hash modulo BUCKETS by a reciprocal multiplication (S_MOD),
// reads the bucket head (S_HEAD, S_HEADW), then walks the chain one node per cycle
// in the node memory (one read port), updating the count of a matching node; with
// no match it inserts a new node at the chain head, then loads the output register.
// an overlong key skips the walk.
// in_tready is low while a key is being resolved; bytes of the next key are
// taken while a result still waits in the output register.
// after reset the bucket head memory is cleared one entry per cycle with in_tready
// low. the node pool is empty after reset.
// a stalled receiver holds the result in the output register; the following
// key is resolved and then waits for that register to free up.
module hashed_key_frequency_counter
  import hkfc_pkg::*;
#(
  parameter int BUCKETS       = 1024,
  parameter int POOL_NODES    = 4096,
  parameter int MAX_KEY_BYTES = 15,
  parameter int COUNT_BITS    = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // key_byte[7:0]
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // hit_count[19:0] bucket[29:20] unique_total[42:30]
  output logic [OUT_TUSER_W-1:0]      out_tuser   // is_new[0] status[2:1]
);

  localparam int BW     = $clog2(BUCKETS);
  localparam int NB     = $clog2(POOL_NODES);
  localparam int CW     = $clog2(POOL_NODES + 1);
  localparam int KB     = MAX_KEY_BYTES * 8;
  localparam int LV_BIT = KB + NB;
  localparam int CNT_LO = KB + NB + 1;
  localparam int LEN_LO = CNT_LO + COUNT_BITS;
  localparam int ROW_W  = LEN_LO + 4;
  localparam int HW     = NB + 1;

  // ceil(2^(32+BW) / BUCKETS), exact quotient for any 32-bit hash
  localparam longint unsigned RECIP =
    ((64'd1 << (32 + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [15:0] RECIP_LO = 16'(RECIP);
  localparam logic [16:0] RECIP_HI = 17'(RECIP >> 16);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MOD    = 4'd2;
  localparam logic [3:0] S_HEAD   = 4'd3;
  localparam logic [3:0] S_HEADW  = 4'd4;
  localparam logic [3:0] S_NODE   = 4'd5;
  localparam logic [3:0] S_INSERT = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [3:0]            state_r;
  logic [BW-1:0]         clr_r;
  logic [31:0]           hash_r;
  logic [31:0]           hash_nxt;
  logic [1:0]            bit_r;
  logic [47:0]           mlo_r;
  logic [48:0]           mhi_r;
  logic [31:0]           quo_r;
  logic [BW-1:0]         rem_r;
  logic [7:0]            stage_r [MAX_KEY_BYTES];
  logic [KB-1:0]         stage_flat;
  logic [3:0]            len_r;
  logic                  ovf_r;
  logic [CW-1:0]         nodes_r;
  logic [NB-1:0]         cur_r;
  logic [HW-1:0]         headv_r;
  logic [COUNT_BITS-1:0] res_cnt_r;
  logic                  res_new_r;
  status_t               res_status_r;
  logic                  out_valid_r;
  logic [HIT_W-1:0]      out_hit_r;
  logic                  out_new_r;
  logic [BUCKET_W-1:0]   out_bucket_r;
  logic [UNIQ_W-1:0]     out_uniq_r;
  status_t               out_status_r;

  logic                  head_we;
  logic [BW-1:0]         head_waddr;
  logic [HW-1:0]         head_wdata;
  logic [HW-1:0]         head_rdata;
  logic                  node_we;
  logic [NB-1:0]         node_waddr;
  logic [ROW_W-1:0]      node_wdata;
  logic [NB-1:0]         node_raddr;
  logic [ROW_W-1:0]      node_rdata;
  logic                  key_eq;
  logic                  in_acc;
  logic                  out_free;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign hash_nxt  = (hash_r ^ 32'(in_tdata[7:0])) * FNV_PRIME;

  for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_stage
    assign stage_flat[i*8 +: 8] = stage_r[i];
    always_ff @(posedge clk) begin
      if (in_acc && len_r == 4'(i)) begin
        stage_r[i] <= in_tdata[7:0];
      end
    end
  end

  always_comb begin
    key_eq = (node_rdata[LEN_LO +: 4] == len_r);
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (4'(i) < len_r && node_rdata[i*8 +: 8] != stage_r[i]) begin
        key_eq = 1'b0;
      end
    end
  end

  assign cnt_inc = (node_rdata[CNT_LO +: COUNT_BITS] == CNT_MAX) ? CNT_MAX
                 : node_rdata[CNT_LO +: COUNT_BITS] + 1'b1;

  always_comb begin
    head_we    = 1'b0;
    head_waddr = rem_r;
    head_wdata = {1'b1, nodes_r[NB-1:0]};
    node_we    = 1'b0;
    node_waddr = cur_r;
    node_wdata = node_rdata;
    node_raddr = cur_r;
    unique case (state_r)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        head_wdata = '0;
      end
      S_HEADW: begin
        node_raddr = head_rdata[NB-1:0];
      end
      S_NODE: begin
        node_raddr = node_rdata[KB +: NB];
        if (key_eq) begin
          node_we = 1'b1;
          node_wdata[CNT_LO +: COUNT_BITS] = cnt_inc;
        end
      end
      S_INSERT: begin
        if (nodes_r < CW'(POOL_NODES)) begin
          head_we    = 1'b1;
          node_we    = 1'b1;
          node_waddr = nodes_r[NB-1:0];
          node_wdata = {len_r, COUNT_BITS'(1), headv_r[NB], headv_r[NB-1:0], stage_flat};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      hash_r      <= FNV_BASIS;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      nodes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BW'(BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            hash_r <= hash_nxt;
            if (len_r < 4'(MAX_KEY_BYTES)) begin
              len_r <= len_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_tlast) begin
              bit_r   <= '0;
              rem_r   <= '0;
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          bit_r <= bit_r + 1'b1;
          if (bit_r == 2'd0) begin
            mlo_r <= 48'(hash_r) * 48'(RECIP_LO);
          end
          if (bit_r == 2'd1) begin
            mhi_r <= 49'(hash_r) * 49'(RECIP_HI);
          end
          if (bit_r == 2'd2) begin
            quo_r <= 32'(({18'd0, mlo_r} + {1'b0, mhi_r, 16'd0}) >> (32 + BW));
          end
          if (bit_r == 2'd3) begin
            rem_r <= hash_r[BW-1:0] - BW'(quo_r[BW-1:0] * BW'(BUCKETS));
            if (ovf_r) begin
              res_cnt_r    <= '0;
              res_new_r    <= 1'b0;
              res_status_r <= STATUS_LONG;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          state_r <= S_HEADW;
        end
        S_HEADW: begin
          headv_r <= head_rdata;
          cur_r   <= head_rdata[NB-1:0];
          state_r <= head_rdata[NB] ? S_NODE : S_INSERT;
        end
        S_NODE: begin
          if (key_eq) begin
            res_cnt_r    <= cnt_inc;
            res_new_r    <= 1'b0;
            res_status_r <= STATUS_OK;
            state_r      <= S_OUT;
          end else if (node_rdata[LV_BIT]) begin
            cur_r <= node_rdata[KB +: NB];
          end else begin
            state_r <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (nodes_r < CW'(POOL_NODES)) begin
            nodes_r      <= nodes_r + 1'b1;
            res_cnt_r    <= COUNT_BITS'(1);
            res_new_r    <= 1'b1;
            res_status_r <= STATUS_OK;
          end else begin
            res_cnt_r    <= '0;
            res_new_r    <= 1'b0;
            res_status_r <= STATUS_FULL;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            hash_r      <= FNV_BASIS;
            len_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_hit_r    <= HIT_W'(res_cnt_r);
      out_new_r    <= res_new_r;
      out_bucket_r <= BUCKET_W'(rem_r);
      out_uniq_r   <= UNIQ_W'(nodes_r);
      out_status_r <= res_status_r;
    end
  end

  hkfc_ram #(.WIDTH(HW), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (rem_r),
    .rdata (head_rdata)
  );

  hkfc_ram #(.WIDTH(ROW_W), .DEPTH(POOL_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_uniq_r, out_bucket_r, out_hit_r};
  assign out_tuser  = {out_status_r, out_new_r};

endmodule
`default_nettype wire

[hdl/hkfc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module hkfc_checker
  import hkfc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] == STATUS_OK || out_tuser[2:1] == STATUS_FULL
                   || out_tuser[2:1] == STATUS_LONG)
    else $error("bad status code");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] != STATUS_OK |-> out_tdata[19:0] == 20'd0 && !out_tuser[0])
    else $error("dropped key reports a count");

  a_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[19:0] == 20'd1 && out_tdata[42:30] != 13'd0)
    else $error("new key without count one");

endmodule

bind hashed_key_frequency_counter hkfc_checker u_hkfc_checker (.*);
`default_nettype wire

[dv/hashed_key_frequency_counter_test.sv]
`timescale 1ns / 1ps
module hashed_key_frequency_counter_test;
  import hkfc_pkg::*;

  localparam int NBUCKETS  = 1024;
  localparam int NPOOL     = 4096;
  localparam int MAXKEY    = 15;
  localparam int CNT_MAX   = (1 << 20) - 1;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [HIT_W-1:0]    hit;
    logic                is_new;
    logic [BUCKET_W-1:0] bucket;
    logic [UNIQ_W-1:0]   uniq;
    status_t             status;
  } tally_t;

  typedef struct {
    int unsigned    len;
    logic [7:0]     b [0:19];
  } key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  hashed_key_frequency_counter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // running key state and stored key counts
  logic [31:0]      fnv_acc = FNV_BASIS;
  logic [14:0][7:0] staged = '0;
  int unsigned      staged_len = 0;
  logic             too_long = 1'b0;
  int unsigned      key_counts [logic [127:0]];
  tally_t           pending_tallies [$];
  key_t             sent_keys [$];

  int errors = 0;
  int burst_left = 0;
  int hold_cycles = 0;

  function automatic void fold_byte(input logic [7:0] kb, input logic kl);
    tally_t t;
    logic [127:0] id;
    fnv_acc = (fnv_acc ^ {24'd0, kb}) * FNV_PRIME;
    if (staged_len < MAXKEY) begin
      staged[staged_len] = kb;
      staged_len++;
    end else begin
      too_long = 1'b1;
    end
    if (!kl) return;
    t.hit = '0;
    t.is_new = 1'b0;
    t.status = STATUS_OK;
    t.bucket = BUCKET_W'(fnv_acc % NBUCKETS);
    id = {4'(staged_len), staged};
    if (too_long) begin
      t.status = STATUS_LONG;
    end else if (key_counts.exists(id)) begin
      if (key_counts[id] < CNT_MAX) key_counts[id]++;
      t.hit = HIT_W'(key_counts[id]);
    end else if (key_counts.num() >= NPOOL) begin
      t.status = STATUS_FULL;
    end else begin
      key_counts[id] = 1;
      t.hit = HIT_W'(1);
      t.is_new = 1'b1;
    end
    t.uniq = UNIQ_W'(key_counts.num());
    pending_tallies.push_back(t);
    fnv_acc = FNV_BASIS;
    staged = '0;
    staged_len = 0;
    too_long = 1'b0;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] kb, input logic kl);
    in_tvalid = 1'b1;
    in_tdata = kb;
    in_tlast = kl;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_byte(kb, kl);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  task automatic send_key(input key_t k);
    for (int i = 0; i < k.len; i++) send_byte(k.b[i], i == k.len - 1);
  endtask

  function automatic key_t random_key(input int unsigned len);
    key_t k;
    k.len = len;
    for (int i = 0; i < 20; i++) k.b[i] = $urandom_range(0, 255);
    return k;
  endfunction

  task automatic test_directed();
    key_t k;
    k = random_key(1); k.b[0] = 8'h00; send_key(k); send_key(k);
    k = random_key(1); k.b[0] = 8'hff; send_key(k);
    k = random_key(2); k.b[0] = 8'h00; k.b[1] = 8'h00; send_key(k);
    k = random_key(MAXKEY); send_key(k);
    k.len = MAXKEY + 1; send_key(k);
    k = random_key(3); k.b[0] = 8'h31; k.b[1] = 8'h2e; k.b[2] = 8'h32; send_key(k);
    send_key(k);
    k.b[2] = 8'h33; send_key(k);
  endtask

  task automatic test_random(input int n_bytes);
    key_t k;
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      if (sent_keys.size() > 0 && $urandom_range(0, 99) < 55) begin
        k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      end else if ($urandom_range(0, 99) < 6) begin
        k = random_key($urandom_range(MAXKEY + 1, 19));
      end else begin
        k = random_key($urandom_range(0, 3) == 0 ? $urandom_range(1, MAXKEY)
                                                 : $urandom_range(1, 5));
        sent_keys.push_back(k);
      end
      send_key(k);
      sent += k.len;
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 2000;
    test_random(150);
  endtask

  // receiver stall pattern
  initial begin
    int stall_pct;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) stall_pct = $urandom_range(0, 2) * 35;
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    tally_t t;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%h", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        t = pending_tallies.pop_front();
        if (out_tdata[19:0] !== t.hit || out_tdata[29:20] !== t.bucket ||
            out_tdata[42:30] !== t.uniq || out_tuser[0] !== t.is_new ||
            out_tuser[2:1] !== t.status) begin
          $display("%0t: mismatch expected hit=%0d bucket=%0d uniq=%0d new=%0d st=%0d",
                   $time, t.hit, t.bucket, t.uniq, t.is_new, t.status);
          $display("%0t:          actual hit=%0d bucket=%0d uniq=%0d new=%0d st=%0d",
                   $time, out_tdata[19:0], out_tdata[29:20], out_tdata[42:30],
                   out_tuser[0], out_tuser[2:1]);
          errors++;
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(1650);
    test_backpressure();
    in_tvalid = 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
